// File: rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 adjugate matrix inverse.
// Used by every module of the block; no dependencies.
package mi3_pkg;

    localparam int N_ELEM    = 9;
    localparam int N_TERM    = 3;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;          // element product, Q32.32
    localparam int COF_W     = PROD_W + 1;          // signed cofactor
    localparam int DABS_W    = 96;                  // |det| magnitude, Q48.48
    localparam int DET_W     = DABS_W + 1;          // signed determinant
    localparam int QBITS     = 32;                  // quotient bits per element
    localparam int WIDE_W    = DABS_W + QBITS;      // divisor shifted by up to 31 bits
    localparam int DIV_STEPS = QBITS;
    localparam int DET_DLY   = 5;                   // stages in the determinant path
    localparam int PIPE_LAT  = 42;                  // register levels before the output stage
    localparam int SING_DLY  = DIV_STEPS + 2;       // singular flag levels up to lane output

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic [3:0]               t_idx;

    typedef struct packed {
        logic [PROD_W-1:0] mag;
        logic              neg;
    } t_cof;

    // Cofactor k = m[P]*m[Q] - m[R]*m[S], already transposed for the adjugate.
    localparam t_idx COF_P [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx COF_Q [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx COF_R [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx COF_S [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // Determinant expansion along row 0: m0j times cofactor TERM_COF[j].
    localparam t_idx TERM_COF [N_TERM] = '{4'd0, 4'd3, 4'd6};

    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// File: rtl/matrix3x3_inverse_core.sv
// Top level of the 3x3 adjugate matrix inverse: front end, determinant path,
// nine division lanes and the output merge. Depends on mi3_pkg and all mi3_ modules.
//
// Usage:
//   Input channel: i_in_valid with the nine Q16.16 elements, o_in_stall back.
//   An item enters at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with o_singular and nine Q16.16 inverse
//   elements, i_out_stall back; an item leaves when o_out_valid is high and
//   i_out_stall is low.
//   Throughput is one item per cycle unless the receiver stalls: the whole pipeline
//   moves together, and each lane holds a 32-stage restoring divider (one quotient
//   bit per stage).
//   When the receiver stalls a waiting result, every stage holds and
//   o_in_stall rises in the same cycle; it drops as soon as the result goes.
//   det_min is written through i_cfg_we / i_cfg_wdata; the user must do so only
//   while idle (not enforced by the block). Reset (i_rst_n low, synchronous) empties
//   the pipeline and sets det_min to 1, that is 2^-16. A matrix whose |det| is zero
//   or below det_min comes out with o_singular set and all inverse elements zero.
module matrix3x3_inverse_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [31:0]                i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [31:0]         i_m00,
    input  logic signed [31:0]         i_m01,
    input  logic signed [31:0]         i_m02,
    input  logic signed [31:0]         i_m10,
    input  logic signed [31:0]         i_m11,
    input  logic signed [31:0]         i_m12,
    input  logic signed [31:0]         i_m20,
    input  logic signed [31:0]         i_m21,
    input  logic signed [31:0]         i_m22,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_singular,
    output logic signed [31:0]         o_i00,
    output logic signed [31:0]         o_i01,
    output logic signed [31:0]         o_i02,
    output logic signed [31:0]         o_i10,
    output logic signed [31:0]         o_i11,
    output logic signed [31:0]         o_i12,
    output logic signed [31:0]         o_i20,
    output logic signed [31:0]         o_i21,
    output logic signed [31:0]         o_i22
);

    // Pipeline advance: everything moves unless a finished item is held.
    logic                             w_ce;
    mi3_pkg::t_elem                   w_m    [mi3_pkg::N_ELEM];
    mi3_pkg::t_elem                   w_a    [mi3_pkg::N_TERM];
    mi3_pkg::t_cof                    w_cof1 [mi3_pkg::N_ELEM];
    mi3_pkg::t_cof                    w_cof2 [mi3_pkg::N_ELEM];
    logic [mi3_pkg::DABS_W-1:0]       w_dabs;
    logic                             w_dneg;
    logic [mi3_pkg::ELEM_W-1:0]       w_res  [mi3_pkg::N_ELEM];
    logic [mi3_pkg::DABS_W-1:0]       w_thr;

    logic [31:0]                      r_det_min;
    logic [mi3_pkg::PIPE_LAT-1:0]     r_vld;
    logic                             r_out_valid;
    logic                             r_sing [mi3_pkg::SING_DLY];
    logic                             r_out_sing;
    logic [mi3_pkg::ELEM_W-1:0]       r_out  [mi3_pkg::N_ELEM];

    assign w_ce       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_ce;

    assign w_m[0] = i_m00;
    assign w_m[1] = i_m01;
    assign w_m[2] = i_m02;
    assign w_m[3] = i_m10;
    assign w_m[4] = i_m11;
    assign w_m[5] = i_m12;
    assign w_m[6] = i_m20;
    assign w_m[7] = i_m21;
    assign w_m[8] = i_m22;

    mi3_front u_front (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_m   (w_m),
        .o_a   (w_a),
        .o_cof (w_cof1)
    );

    mi3_det u_det (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_a    (w_a),
        .i_cof  (w_cof1),
        .o_cof  (w_cof2),
        .o_dabs (w_dabs),
        .o_dneg (w_dneg)
    );

    // One divider lane per inverse element; all share |det| and its sign.
    for (genvar k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_lane
        mi3_lane u_lane (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_cof  (w_cof2[k]),
            .i_dabs (w_dabs),
            .i_dneg (w_dneg),
            .o_res  (w_res[k])
        );
    end

    // Threshold is det_min (Q16.16) lined up with the Q48.48 determinant.
    assign w_thr = {{(mi3_pkg::DABS_W - 64){1'b0}}, r_det_min, 32'h0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_min <= 32'd1;
        end else if (i_cfg_we) begin
            r_det_min <= i_cfg_wdata;
        end
    end

    // Control: item valid bits through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_vld       <= {r_vld[mi3_pkg::PIPE_LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[mi3_pkg::PIPE_LAT-1];
        end
    end

    // Singular decision runs beside the lanes, then gates the merged result.
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sing[0] <= (w_dabs == '0) || (w_dabs < w_thr);
            for (int s = 1; s < mi3_pkg::SING_DLY; s++) begin
                r_sing[s] <= r_sing[s-1];
            end
            r_out_sing <= r_sing[mi3_pkg::SING_DLY-1];
            for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
                r_out[k] <= r_sing[mi3_pkg::SING_DLY-1] ? '0 : w_res[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_singular  = r_out_sing;
    assign o_i00 = r_out[0];
    assign o_i01 = r_out[1];
    assign o_i02 = r_out[2];
    assign o_i10 = r_out[3];
    assign o_i11 = r_out[4];
    assign o_i12 = r_out[5];
    assign o_i20 = r_out[6];
    assign o_i21 = r_out[7];
    assign o_i22 = r_out[8];

endmodule

// File: rtl/mi3_front.sv
// Cofactor front end: element products, cofactor differences, magnitude and sign,
// plus the row-0 elements delayed for the determinant path. Depends on mi3_pkg.
module mi3_front (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  mi3_pkg::t_elem       i_m   [mi3_pkg::N_ELEM],
    output mi3_pkg::t_elem       o_a   [mi3_pkg::N_TERM],
    output mi3_pkg::t_cof        o_cof [mi3_pkg::N_ELEM]
);

    logic signed [mi3_pkg::PROD_W-1:0] r_pq [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::PROD_W-1:0] r_rs [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::COF_W-1:0]  r_c  [mi3_pkg::N_ELEM];
    mi3_pkg::t_cof                     r_cof [mi3_pkg::N_ELEM];
    mi3_pkg::t_elem                    r_a1 [mi3_pkg::N_TERM];
    mi3_pkg::t_elem                    r_a2 [mi3_pkg::N_TERM];
    mi3_pkg::t_elem                    r_a3 [mi3_pkg::N_TERM];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
                r_pq[k] <= i_m[mi3_pkg::COF_P[k]] * i_m[mi3_pkg::COF_Q[k]];
                r_rs[k] <= i_m[mi3_pkg::COF_R[k]] * i_m[mi3_pkg::COF_S[k]];
                r_c[k]  <= mi3_pkg::COF_W'(r_pq[k]) - mi3_pkg::COF_W'(r_rs[k]);
                r_cof[k].neg <= r_c[k][mi3_pkg::COF_W-1];
                r_cof[k].mag <= r_c[k][mi3_pkg::COF_W-1]
                              ? mi3_pkg::PROD_W'(-r_c[k])
                              : r_c[k][mi3_pkg::PROD_W-1:0];
            end
            for (int t = 0; t < mi3_pkg::N_TERM; t++) begin
                r_a1[t] <= i_m[t];
                r_a2[t] <= r_a1[t];
                r_a3[t] <= r_a2[t];
            end
        end
    end

    assign o_a   = r_a3;
    assign o_cof = r_cof;

endmodule

// File: rtl/mi3_det.sv
// Determinant path: row-0 expansion terms split into 32x32 partial products,
// signed sum and magnitude. Carries the cofactors alongside. Depends on mi3_pkg.
module mi3_det (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  mi3_pkg::t_elem              i_a    [mi3_pkg::N_TERM],
    input  mi3_pkg::t_cof               i_cof  [mi3_pkg::N_ELEM],
    output mi3_pkg::t_cof               o_cof  [mi3_pkg::N_ELEM],
    output logic [mi3_pkg::DABS_W-1:0]  o_dabs,
    output logic                        o_dneg
);

    logic [mi3_pkg::ELEM_W-1:0]       w_am  [mi3_pkg::N_TERM];
    logic [mi3_pkg::PROD_W-1:0]       r_plo [mi3_pkg::N_TERM];
    logic [mi3_pkg::PROD_W-1:0]       r_phi [mi3_pkg::N_TERM];
    logic                             r_tn1 [mi3_pkg::N_TERM];
    logic                             r_tn2 [mi3_pkg::N_TERM];
    logic [mi3_pkg::DABS_W-1:0]       r_tmag [mi3_pkg::N_TERM];
    logic signed [mi3_pkg::DET_W-1:0] r_term [mi3_pkg::N_TERM];
    logic signed [mi3_pkg::DET_W-1:0] r_det;
    logic [mi3_pkg::DABS_W-1:0]       r_dabs;
    logic                             r_dneg;
    mi3_pkg::t_cof                    r_cd [mi3_pkg::DET_DLY][mi3_pkg::N_ELEM];

    always_comb begin
        for (int t = 0; t < mi3_pkg::N_TERM; t++) begin
            w_am[t] = i_a[t][mi3_pkg::ELEM_W-1] ? mi3_pkg::ELEM_W'(-i_a[t]) : i_a[t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int t = 0; t < mi3_pkg::N_TERM; t++) begin
                r_plo[t]  <= w_am[t] * i_cof[mi3_pkg::TERM_COF[t]].mag[mi3_pkg::ELEM_W-1:0];
                r_phi[t]  <= w_am[t] *
                             i_cof[mi3_pkg::TERM_COF[t]].mag[mi3_pkg::PROD_W-1:mi3_pkg::ELEM_W];
                r_tn1[t]  <= i_a[t][mi3_pkg::ELEM_W-1] ^ i_cof[mi3_pkg::TERM_COF[t]].neg;
                r_tmag[t] <= mi3_pkg::DABS_W'(r_plo[t])
                           + {r_phi[t], {mi3_pkg::ELEM_W{1'b0}}};
                r_tn2[t]  <= r_tn1[t];
                r_term[t] <= r_tn2[t] ? -mi3_pkg::DET_W'(r_tmag[t])
                                      :  mi3_pkg::DET_W'(r_tmag[t]);
            end
            r_det  <= r_term[0] + r_term[1] + r_term[2];
            r_dneg <= r_det[mi3_pkg::DET_W-1];
            r_dabs <= r_det[mi3_pkg::DET_W-1] ? mi3_pkg::DABS_W'(-r_det)
                                              : r_det[mi3_pkg::DABS_W-1:0];
            r_cd[0] <= i_cof;
            for (int s = 1; s < mi3_pkg::DET_DLY; s++) begin
                r_cd[s] <= r_cd[s-1];
            end
        end
    end

    assign o_cof  = r_cd[mi3_pkg::DET_DLY-1];
    assign o_dabs = r_dabs;
    assign o_dneg = r_dneg;

endmodule

// File: rtl/mi3_lane.sv
// One division lane: |cofactor| * 2^32 / |det|, restoring, one quotient bit per
// stage, then sign and saturation to Q16.16. Depends on mi3_pkg.
module mi3_lane (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  mi3_pkg::t_cof               i_cof,
    input  logic [mi3_pkg::DABS_W-1:0]  i_dabs,
    input  logic                        i_dneg,
    output logic [mi3_pkg::ELEM_W-1:0]  o_res
);

    logic [mi3_pkg::DABS_W-1:0] r_rem [mi3_pkg::DIV_STEPS+1];
    logic [mi3_pkg::DABS_W-1:0] r_d   [mi3_pkg::DIV_STEPS+1];
    logic [mi3_pkg::QBITS-1:0]  r_q   [mi3_pkg::DIV_STEPS+1];
    logic                       r_neg [mi3_pkg::DIV_STEPS+1];
    logic                       r_ovf [mi3_pkg::DIV_STEPS+1];
    logic [mi3_pkg::ELEM_W-1:0] r_res;

    // Quotient needs more than 32 bits when |c| >= |det|.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= {i_cof.mag, {mi3_pkg::QBITS{1'b0}}};
            r_d[0]   <= i_dabs;
            r_q[0]   <= '0;
            r_neg[0] <= i_cof.neg ^ i_dneg;
            r_ovf[0] <= mi3_pkg::DABS_W'(i_cof.mag) >= i_dabs;
        end
    end

    for (genvar s = 1; s <= mi3_pkg::DIV_STEPS; s++) begin : g_step
        localparam int SH = mi3_pkg::DIV_STEPS - s;
        logic [mi3_pkg::WIDE_W-1:0] w_rem;
        logic [mi3_pkg::WIDE_W-1:0] w_dsh;
        logic [mi3_pkg::WIDE_W-1:0] w_diff;
        logic                       w_take;

        assign w_rem  = {{mi3_pkg::QBITS{1'b0}}, r_rem[s-1]};
        assign w_dsh  = {{mi3_pkg::QBITS{1'b0}}, r_d[s-1]} << SH;
        assign w_diff = w_rem - w_dsh;
        assign w_take = (w_rem >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= w_take ? w_diff[mi3_pkg::DABS_W-1:0] : r_rem[s-1];
                r_d[s]   <= r_d[s-1];
                r_q[s]   <= r_q[s-1] | (w_take ? (mi3_pkg::QBITS'(1) << SH) : '0);
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (r_ovf[mi3_pkg::DIV_STEPS] || r_q[mi3_pkg::DIV_STEPS][mi3_pkg::QBITS-1]) begin
                r_res <= r_neg[mi3_pkg::DIV_STEPS] ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
            end else begin
                r_res <= r_neg[mi3_pkg::DIV_STEPS] ? -r_q[mi3_pkg::DIV_STEPS]
                                                   :  r_q[mi3_pkg::DIV_STEPS];
            end
        end
    end

    assign o_res = r_res;

endmodule
